// ----- design/dkwa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dkwa_pkg;

	localparam int COORD_W       = 32;
	localparam int CELL_INDEX_W  = 20;
	localparam int POINT_INDEX_W = 16;
	localparam int WEIGHT_W      = 31;
	localparam int INV_W         = 32;
	localparam int PHI_W         = 32;
	localparam int DIST_W        = 33;

	// square root unit: digit pairs of the radicand, one root bit per step
	localparam int RAD_W         = 64;
	localparam int ROOT_W        = RAD_W / 2;
	localparam int SQRT_STEPS    = 4;
	localparam int SQRT_STAGES   = ROOT_W / SQRT_STEPS;

	// six stages ahead of the root, three after it
	localparam int LANE_LAT      = SQRT_STAGES + 9;

	localparam int CELL_INDEX_BITS_DEF  = 20;
	localparam int POINT_INDEX_BITS_DEF = 16;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_INV_SPACING = 1'b0;
	localparam logic [INV_W-1:0] INV_SPACING_RST = 32'h0001_0000;

	// (2/3)^2 in Q.31, rounded up
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 31'h38E3_8E39;

	typedef struct packed {
		logic signed [COORD_W-1:0] cell_x;
		logic signed [COORD_W-1:0] cell_y;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [CELL_INDEX_W-1:0]   cell_index;
		logic [POINT_INDEX_W-1:0]  point_index;
	} pair_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0]      weight;
		logic [CELL_INDEX_W-1:0]  cell_index_out;
		logic [POINT_INDEX_W-1:0] point_index_out;
	} assoc_t;

endpackage

`default_nettype wire

// ----- design/dkwa_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dkwa_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [dkwa_pkg::COORD_W-1:0] a,
	input  logic signed [dkwa_pkg::COORD_W-1:0] b,
	input  logic [dkwa_pkg::INV_W-1:0]          inv_spacing,
	output logic [dkwa_pkg::PHI_W-1:0]          phi,
	output logic                                sat
);
	import dkwa_pkg::*;

	localparam int HALF_W = 16;
	localparam int PROD_W = DIST_W + INV_W;
	localparam int REM_W  = ROOT_W + 4;
	localparam int M_W    = 34;
	localparam int Q0_W   = 33;

	localparam logic [PROD_W-1:0] SUPPORT  = 65'h1_8000_0000;
	localparam logic [DIST_W-1:0] HALF_Q32 = 33'h0_8000_0000;
	localparam logic [DIST_W-1:0] ONE_Q32  = 33'h1_0000_0000;
	localparam logic [RAD_W-1:0]  ONE_Q62  = 64'h4000_0000_0000_0000;
	localparam logic [31:0]       DIV3_K   = 32'h5555_5555;

	// stage 1: magnitude of the difference
	logic signed [DIST_W-1:0] diff;
	logic [DIST_W-1:0]        mag_s1;

	assign diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};

	// stage 2: split product, upper and lower halves of the magnitude
	logic [DIST_W-HALF_W+INV_W-1:0] p_hi_s2;
	logic [HALF_W+INV_W-1:0]        p_lo_s2;

	// stage 3: scaled distance and support test
	logic [PROD_W-1:0] prod;
	logic [DIST_W-1:0] r_s3;
	logic              sat_s3;

	assign prod = {p_hi_s2, {HALF_W{1'b0}}} + PROD_W'(p_lo_s2);

	// stage 4: offset from the nearer node
	logic [31:0]       u_c;
	logic [31:0]       u_s4;
	logic [DIST_W-1:0] r_s4;
	logic              sat_s4;

	always_comb begin
		if (r_s3 <= HALF_Q32) begin
			u_c = r_s3[31:0];
		end else if (r_s3 >= ONE_Q32) begin
			u_c = 32'(r_s3 - ONE_Q32);
		end else begin
			u_c = 32'(ONE_Q32 - r_s3);
		end
	end

	// stage 5: u squared
	logic [RAD_W-1:0]  sq_s5;
	logic [DIST_W-1:0] r_s5;
	logic              sat_s5;

	// stage 6: radicand 1 - 3u^2 in Q.62
	logic [RAD_W-3:0]  quarter;
	logic [RAD_W-1:0]  rad_s6;
	logic [DIST_W-1:0] r_s6;
	logic              sat_s6;

	assign quarter = sq_s5[RAD_W-1:2];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

			p_hi_s2 <= (DIST_W-HALF_W+INV_W)'(mag_s1[DIST_W-1:HALF_W])
				* (DIST_W-HALF_W+INV_W)'(inv_spacing);
			p_lo_s2 <= (HALF_W+INV_W)'(mag_s1[HALF_W-1:0]) * (HALF_W+INV_W)'(inv_spacing);

			r_s3    <= prod[DIST_W-1:0];
			sat_s3  <= (prod >= SUPPORT);

			u_s4    <= u_c;
			r_s4    <= r_s3;
			sat_s4  <= sat_s3;

			sq_s5   <= RAD_W'(u_s4) * RAD_W'(u_s4);
			r_s5    <= r_s4;
			sat_s5  <= sat_s4;

			rad_s6  <= ONE_Q62 - (RAD_W'(quarter) + {quarter, 1'b0});
			r_s6    <= r_s5;
			sat_s6  <= sat_s5;
		end
	end

	// square root: SQRT_STEPS root bits per stage
	logic [REM_W-1:0]  sq_rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] sq_root_s [SQRT_STAGES];
	logic [RAD_W-1:0]  sq_rad_s  [SQRT_STAGES];
	logic [DIST_W-1:0] sq_r_s    [SQRT_STAGES];
	logic              sq_sat_s  [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		logic [REM_W-1:0]  rem_i, rem_c, rem_t, trial;
		logic [ROOT_W-1:0] root_i, root_c;
		logic [RAD_W-1:0]  rad_i, rad_c;
		logic [DIST_W-1:0] r_i;
		logic              sat_i;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad_s6;
			assign r_i    = r_s6;
			assign sat_i  = sat_s6;
		end else begin : g_next
			assign rem_i  = sq_rem_s[k-1];
			assign root_i = sq_root_s[k-1];
			assign rad_i  = sq_rad_s[k-1];
			assign r_i    = sq_r_s[k-1];
			assign sat_i  = sq_sat_s[k-1];
		end

		always_comb begin
			rem_c  = rem_i;
			root_c = root_i;
			rad_c  = rad_i;
			rem_t  = '0;
			trial  = '0;
			for (int j = 0; j < SQRT_STEPS; j++) begin
				rem_t = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
				rad_c = {rad_c[RAD_W-3:0], 2'b00};
				trial = REM_W'({root_c, 2'b01});
				if (rem_t >= trial) begin
					rem_c  = rem_t - trial;
					root_c = {root_c[ROOT_W-2:0], 1'b1};
				end else begin
					rem_c  = rem_t;
					root_c = {root_c[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k]  <= rem_c;
				sq_root_s[k] <= root_c;
				sq_rad_s[k]  <= rad_c;
				sq_r_s[k]    <= r_i;
				sq_sat_s[k]  <= sat_i;
			end
		end
	end

	// numerator over 6, halved so that one divide by 3 serves both pieces
	logic [ROOT_W-1:0] root;
	logic [DIST_W-1:0] rr;
	logic [34:0]       n_one;
	logic [36:0]       n_two;
	logic [M_W-1:0]    m_c;

	assign root  = sq_root_s[SQRT_STAGES-1];
	assign rr    = sq_r_s[SQRT_STAGES-1];
	assign n_one = 35'h2_0000_0000 + 35'({root, 2'b00});
	assign n_two = 37'h05_0000_0000 - (37'(rr) + 37'({rr, 1'b0})) - 37'({root, 1'b0});

	always_comb begin
		if (rr <= HALF_Q32) begin
			m_c = M_W'(n_one >> 1);
		end else if (n_two[36]) begin
			m_c = '0;
		end else begin
			m_c = M_W'(n_two >> 1);
		end
	end

	logic [M_W-1:0]         m_s15, m_s16;
	logic                   sat_s15, sat_s16, sat_s17;
	logic [M_W+32-1:0]      q_prod;
	logic [Q0_W-1:0]        q0_s16;
	logic [3:0]             rem4;
	logic [1:0]             corr;
	logic [PHI_W-1:0]       phi_s17;

	assign q_prod = (M_W+32)'(m_s15) * (M_W+32)'(DIV3_K);

	// reciprocal quotient is low by at most two; remainder fits in four bits
	assign rem4 = m_s16[3:0] - 4'(q0_s16[3:0] + {q0_s16[2:0], 1'b0});

	always_comb begin
		if (rem4 >= 4'd6) begin
			corr = 2'd2;
		end else if (rem4 >= 4'd3) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s15   <= m_c;
			sat_s15 <= sq_sat_s[SQRT_STAGES-1];

			q0_s16  <= Q0_W'(q_prod >> 32);
			m_s16   <= m_s15;
			sat_s16 <= sat_s15;

			phi_s17 <= PHI_W'(q0_s16 + Q0_W'(corr));
			sat_s17 <= sat_s16;
		end
	end

	assign phi = phi_s17;
	assign sat = sat_s17;

endmodule

`default_nettype wire

// ----- design/delta_kernel_weight_association.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// pair      in         pair_valid / pair_stall  pair_t: positions and indices
// assoc     out        assoc_valid / assoc_stall assoc_t: weight and indices
// config    in/out     APB, pready tied high    inv_spacing at byte address 0
//
// One request per cycle while the output is not held; each passes 17 lane stages,
// of which 8 form the square root unit, then the weight product and output register.
// The pipeline moves as one; a held result freezes it and one further request
// waits in a skid entry, so pair_stall comes straight from a register.
// Reset clears the valid bits and the skid entry and sets inv_spacing to 1.0.
// Requests outside the kernel support retire as bubbles.

module delta_kernel_weight_association #(
	parameter int CELL_INDEX_BITS  = dkwa_pkg::CELL_INDEX_BITS_DEF,
	parameter int POINT_INDEX_BITS = dkwa_pkg::POINT_INDEX_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             pair_valid,
	output logic                             pair_stall,
	input  dkwa_pkg::pair_t                  pair,

	output logic                             assoc_valid,
	input  logic                             assoc_stall,
	output dkwa_pkg::assoc_t                 assoc,

	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dkwa_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [dkwa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [dkwa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import dkwa_pkg::*;

	localparam int CELL_KEEP  = (CELL_INDEX_BITS < CELL_INDEX_W) ? CELL_INDEX_BITS
		: CELL_INDEX_W;
	localparam int POINT_KEEP = (POINT_INDEX_BITS < POINT_INDEX_W) ? POINT_INDEX_BITS
		: POINT_INDEX_W;

	// configuration
	logic [INV_W-1:0] inv_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_INV_SPACING);
	assign prdata  = reg_sel ? APB_DATA_W'(inv_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_SPACING_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			inv_q <= INV_W'(pwdata);
		end
	end

	// skid entry and pipeline advance
	logic  pipe_en;
	logic  skid_vld_q;
	pair_t skid_q;
	logic  enter_vld;
	pair_t enter;
	logic  out_vld_q;

	assign pipe_en    = !out_vld_q || !assoc_stall;
	assign pair_stall = skid_vld_q;
	assign enter_vld  = skid_vld_q || pair_valid;
	assign enter      = skid_vld_q ? skid_q : pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (pipe_en) begin
			skid_vld_q <= 1'b0;
		end else if (pair_valid && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!pipe_en && pair_valid && !skid_vld_q) begin
			skid_q <= pair;
		end
	end

	// kernel lanes
	logic [PHI_W-1:0] phi_x, phi_y;
	logic             sat_x, sat_y;

	dkwa_lane u_lane_x (
		.clk         (clk),
		.en          (pipe_en),
		.a           (enter.cell_x),
		.b           (enter.point_x),
		.inv_spacing (inv_q),
		.phi         (phi_x),
		.sat         (sat_x)
	);

	dkwa_lane u_lane_y (
		.clk         (clk),
		.en          (pipe_en),
		.a           (enter.cell_y),
		.b           (enter.point_y),
		.inv_spacing (inv_q),
		.phi         (phi_y),
		.sat         (sat_y)
	);

	// valid bits and indices alongside the lanes
	logic                  vld_s  [LANE_LAT];
	logic [CELL_KEEP-1:0]  cidx_s [LANE_LAT];
	logic [POINT_KEEP-1:0] pidx_s [LANE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (pipe_en) begin
			vld_s[0] <= enter_vld;
			for (int i = 1; i < LANE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cidx_s[0] <= enter.cell_index[CELL_KEEP-1:0];
			pidx_s[0] <= enter.point_index[POINT_KEEP-1:0];
			for (int i = 1; i < LANE_LAT; i++) begin
				cidx_s[i] <= cidx_s[i-1];
				pidx_s[i] <= pidx_s[i-1];
			end
		end
	end

	// weight product and output register
	logic [2*PHI_W-1:0] w_prod;
	assoc_t             out_q;

	assign w_prod = (2*PHI_W)'(phi_x) * (2*PHI_W)'(phi_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pipe_en) begin
			out_vld_q <= vld_s[LANE_LAT-1] && !sat_x && !sat_y;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_q.weight          <= w_prod[2*PHI_W-1 -: WEIGHT_W];
			out_q.cell_index_out  <= CELL_INDEX_W'(cidx_s[LANE_LAT-1]);
			out_q.point_index_out <= POINT_INDEX_W'(pidx_s[LANE_LAT-1]);
		end
	end

	assign assoc_valid = out_vld_q;
	assign assoc       = out_q;

	// a request taken while the pipeline is held must land in the skid entry
	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_stall && !pipe_en |=> skid_vld_q)
		else $error("request accepted during hold not kept");

	// a held skid entry keeps its request
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !pipe_en |=> skid_vld_q && $stable(skid_q))
		else $error("skid entry lost while held");

	// out of support gives no result
	a_no_sat_result: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_en && vld_s[LANE_LAT-1] && (sat_x || sat_y) |=> !assoc_valid)
		else $error("result from a distance outside support");

	// product of two kernel values never exceeds (2/3)^2
	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		assoc_valid |-> assoc.weight <= WEIGHT_MAX)
		else $error("weight above kernel peak");

endmodule

`default_nettype wire
